// File: design/pam_pkg.sv
// pam_pkg: shared types and codes for the polynomial add/multiply core
// item and term payload structs, mode codes, register indexes, queue sizing
// no dependencies
package pam_pkg;

  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_COMPUTE     = 2'd2;

  localparam int         CFG_DATA_W         = 4;
  localparam logic       REG_DEGREE_FIRST   = 1'b0;
  localparam logic       REG_DEGREE_SECOND  = 1'b1;

  localparam int         QUEUE_DEPTH = 4;
  localparam int         QPTR_W      = 2;
  localparam int         QCNT_W      = 3;

  typedef struct packed {
    logic [1:0]          mode;
    logic [3:0]          term_index;
    logic signed [15:0]  coefficient_in;
  } item_t;

  typedef struct packed {
    logic                is_product;
    logic [4:0]          exponent;
    logic signed [35:0]  coefficient_out;
    logic                last_term;
  } term_t;

endpackage

// File: design/pam_front.sv
// pam_front: input side, accepts items and drops those with no effect
// depends on pam_pkg; feeds pam_queue
module pam_front import pam_pkg::*; #(
  parameter int MAX_DEGREE = 15
) (
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  q_full,
  output logic  q_push,
  output item_t q_data
);

  logic is_load;
  logic keep;

  // unused mode and loads beyond the store never reach the back end
  always_comb begin
    is_load = (item.mode == MODE_LOAD_FIRST) || (item.mode == MODE_LOAD_SECOND);
    keep    = (item.mode == MODE_COMPUTE) ||
              (is_load && (int'(item.term_index) <= MAX_DEGREE));
  end

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full && keep;
  assign q_data     = item;

endmodule

// File: design/pam_queue.sv
// pam_queue: short fifo between the front and back of the core
// depends on pam_pkg
module pam_queue import pam_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  output logic  head_valid,
  output item_t head,
  input  logic  pop
);

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/pam_back.sv
// pam_back: coefficient stores, degree registers, sum walk, product mac and term output
// depends on pam_pkg; fed by pam_queue
module pam_back import pam_pkg::*; #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  item_t                 q_head,
  output logic                  q_pop,
  output logic                  term_valid,
  input  logic                  term_stall,
  output term_t                 term
);

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int EXP_W = IDX_W + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_PROD   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [3:0]          degree_first;
  logic [3:0]          degree_second;
  logic signed [15:0]  first_coeffs  [DEPTH];
  logic signed [15:0]  second_coeffs [DEPTH];

  logic [2:0]          state;
  logic [IDX_W-1:0]    si;
  logic [EXP_W-1:0]    k;
  logic [IDX_W-1:0]    pi;

  logic signed [31:0]  p_prod;
  logic                p_valid;
  logic                p_end;
  logic [EXP_W-1:0]    p_k;
  logic signed [35:0]  acc;

  term_t               pend;
  logic                pend_valid;
  term_t               out_reg;
  logic                out_valid;

  logic [IDX_W-1:0]    n;
  logic [IDX_W-1:0]    m;
  logic [IDX_W-1:0]    top;
  logic signed [15:0]  sum_a;
  logic signed [15:0]  sum_b;
  logic signed [16:0]  sum_s;
  logic [IDX_W-1:0]    hi;
  logic [IDX_W-1:0]    pj;
  logic [EXP_W-1:0]    k_inc;
  logic [EXP_W-1:0]    k_max;
  logic [IDX_W-1:0]    lo_next;
  logic                issue_end;
  logic signed [15:0]  mul_a;
  logic signed [15:0]  mul_b;
  logic signed [35:0]  acc_sum;
  logic                out_free;
  logic                advance;
  logic                cand_valid;
  term_t               cand;
  logic                push;
  term_t               push_item;

  // degrees above the store are saturated
  always_comb begin
    n   = (int'(degree_first)  > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(degree_first);
    m   = (int'(degree_second) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(degree_second);
    top = (n > m) ? n : m;
  end

  // sum walk, one exponent a cycle while the term output is not stalled
  always_comb begin
    sum_a = (si <= n) ? first_coeffs[si]  : '0;
    sum_b = (si <= m) ? second_coeffs[si] : '0;
    sum_s = {sum_a[15], sum_a} + {sum_b[15], sum_b};
  end

  // product walk: outer exponent k, inner i over max(0,k-m)..min(k,n)
  always_comb begin
    hi        = (k < EXP_W'(n)) ? IDX_W'(k) : n;
    pj        = IDX_W'(k - EXP_W'(pi));
    k_inc     = k + 1'b1;
    k_max     = EXP_W'(n) + EXP_W'(m);
    lo_next   = (k_inc > EXP_W'(m)) ? IDX_W'(k_inc - EXP_W'(m)) : '0;
    issue_end = (pi == hi);
    mul_a     = first_coeffs[pi];
    mul_b     = second_coeffs[pj];
    acc_sum   = acc + {{4{p_prod[31]}}, p_prod};
  end

  assign out_free = !out_valid || !term_stall;
  assign advance  = out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // candidate term from the sum walk or the end of one product exponent
  always_comb begin
    cand_valid = 1'b0;
    cand       = '0;
    if (state == ST_SUM) begin
      cand_valid           = (sum_s != '0);
      cand.is_product      = 1'b0;
      cand.exponent        = 5'(si);
      cand.coefficient_out = {{19{sum_s[16]}}, sum_s};
    end else if ((state == ST_PROD || state == ST_DRAIN) && p_valid && p_end) begin
      cand_valid           = (acc_sum != '0);
      cand.is_product      = 1'b1;
      cand.exponent        = 5'(p_k);
      cand.coefficient_out = acc_sum;
    end
  end

  // newest term waits in pend until the next one or the end marks it
  always_comb begin
    push      = 1'b0;
    push_item = pend;
    if (state == ST_FINISH) begin
      push = 1'b1;
      if (pend_valid) begin
        push_item.last_term = 1'b1;
      end else begin
        push_item.is_product      = 1'b1;
        push_item.exponent        = '0;
        push_item.coefficient_out = '0;
        push_item.last_term       = 1'b1;
      end
    end else if (cand_valid && pend_valid) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_first  <= '0;
      degree_second <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEGREE_FIRST:  degree_first  <= cfg_data;
        REG_DEGREE_SECOND: degree_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < DEPTH; e++) begin
        first_coeffs[e]  <= '0;
        second_coeffs[e] <= '0;
      end
    end else if (q_pop) begin
      if (q_head.mode == MODE_LOAD_FIRST) begin
        first_coeffs[IDX_W'(q_head.term_index)] <= q_head.coefficient_in;
      end else if (q_head.mode == MODE_LOAD_SECOND) begin
        second_coeffs[IDX_W'(q_head.term_index)] <= q_head.coefficient_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      p_valid    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      si         <= '0;
      k          <= '0;
      pi         <= '0;
      acc        <= '0;
    end else begin
      if (out_free) begin
        out_valid <= push;
      end
      if (advance && push) begin
        out_reg <= push_item;
      end
      if (advance && cand_valid) begin
        pend       <= cand;
        pend_valid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop && q_head.mode == MODE_COMPUTE) begin
            state   <= ST_SUM;
            si      <= '0;
            k       <= '0;
            pi      <= '0;
            acc     <= '0;
            p_valid <= 1'b0;
          end
        end
        ST_SUM: begin
          if (advance) begin
            if (si == top) begin
              state <= ST_PROD;
            end else begin
              si <= si + 1'b1;
            end
          end
        end
        ST_PROD: begin
          if (advance) begin
            if (p_valid) begin
              acc <= p_end ? '0 : acc_sum;
            end
            p_valid <= 1'b1;
            p_prod  <= mul_a * mul_b;
            p_end   <= issue_end;
            p_k     <= k;
            if (issue_end) begin
              if (k == k_max) begin
                state <= ST_DRAIN;
              end else begin
                k  <= k_inc;
                pi <= lo_next;
              end
            end else begin
              pi <= pi + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (advance) begin
            acc     <= '0;
            p_valid <= 1'b0;
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (advance) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign term_valid = out_valid;
  assign term       = out_reg;

endmodule

// File: design/polynomial_add_multiply_core.sv
// polynomial_add_multiply_core: top level of the polynomial sum and product core
// depends on pam_pkg; instantiates pam_front, pam_queue and pam_back
//
// Loads two dense integer polynomials one coefficient per item (mode 0 first,
// mode 1 second, with an explicit exponent), and on a compute item (mode 2)
// emits every nonzero term of their sum and then of their product, each in
// ascending exponent order, with last_term on the final beat; when all terms
// are zero a single zero product term at exponent 0 is sent, marked last.
// Degrees come from the two configuration registers and saturate at
// MAX_DEGREE; coefficients above a degree count as zero. Unused-mode items
// are dropped at the front; loads and computes go through a four-entry queue
// and a load is written into its store as it leaves the queue. A compute
// leaves the queue, then runs the sum walk, then the product walk on the
// single shared 16x16 multiplier, then drains and closes; a stalled term
// output holds the walk.
module polynomial_add_multiply_core import pam_pkg::*; #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  // term channel
  output logic                  term_valid,
  input  logic                  term_stall,
  output term_t                 term
);

  logic  q_full;
  logic  q_push;
  item_t q_data;
  logic  q_valid;
  item_t q_head;
  logic  q_pop;

  // front: accept beats and drop the ones with no effect
  pam_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  // decoupling queue, lets loads pile up while a compute streams terms
  pam_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  // back: stores, sum walk, mac over the product and the term register
  pam_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .term_valid (term_valid),
    .term_stall (term_stall),
    .term       (term)
  );

endmodule
